// ===== rtl/itrd_pkg.sv =====
// shared constants, types and the digit-to-character function for the radix converter
package itrd_pkg;

  localparam int unsigned ValueW       = 32;
  localparam int unsigned RadixW       = 6;
  localparam int unsigned CharW        = 7;
  localparam int unsigned MaxDigits    = 32;
  localparam int unsigned IdxW         = $clog2(MaxDigits);
  localparam int unsigned CntW         = IdxW + 1;
  localparam int unsigned RemW         = 5;
  localparam int unsigned BitCntW      = $clog2(ValueW);

  localparam logic [RadixW-1:0] RadixLowest  = RadixW'(2);
  localparam logic [RadixW-1:0] RadixHighest = RadixW'(32);
  localparam logic [RadixW-1:0] RadixReset   = RadixW'(10);
  localparam logic [CharW-1:0]  CharDigitZero = CharW'(48);
  localparam logic [CharW-1:0]  CharLetterA   = CharW'(65);

  // divider handshake towards the sequencer
  typedef struct packed {
    logic                start;
    logic [ValueW-1:0]   dividend;
    logic [RadixW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [ValueW-1:0]   quotient;
    logic [RemW-1:0]     remainder;
  } div_rsp_t;

  // ascii for one digit value: '0'..'9' then 'A' onward
  function automatic logic [CharW-1:0] digit_char(logic [RemW-1:0] d);
    logic [CharW-1:0] dx;
    dx = CharW'(d);
    if (d >= RemW'(10)) begin
      digit_char = CharLetterA + dx - CharW'(10);
    end else begin
      digit_char = CharDigitZero + dx;
    end
  endfunction

endpackage

// ===== rtl/integer_to_radix_digits_core.sv =====
// top level: radix register, digit sequencer, digit store and shared divider
//
// Converts an unsigned 32-bit value into ASCII digits in the radix held in the
// radix register (2..32; letters from 'A' for digits of ten and up). A
// transaction is taken when start is high and busy is low. Each digit costs
// one pass of the bit-serial divider, and the stored digits are then read
// back most significant first; radix 10 needs at most 10 digits, radix 2 up
// to 32. Results appear on character_o, last_o and bad_radix_o for exactly
// one cycle with result_valid_o high and cannot be held off. A zero value
// gives one '0'. With the radix outside 2..32 a single result with character
// 0, last and bad_radix set follows in the cycle after the transaction.
// Write the radix only while busy is low and no result is due.
module integer_to_radix_digits_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [itrd_pkg::ValueW-1:0]   value_i,
  input  logic                          radix_we_i,
  input  logic [itrd_pkg::RadixW-1:0]   radix_wdata_i,
  output logic                          result_valid_o,
  output logic [itrd_pkg::CharW-1:0]    character_o,
  output logic                          last_o,
  output logic                          bad_radix_o
);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StDivide = 4'b0010,
    StRead   = 4'b0100,
    StOut    = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  logic [itrd_pkg::RadixW-1:0]  radix_q;
  logic [itrd_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [itrd_pkg::IdxW-1:0]    ptr_q, ptr_d;
  logic                         valid_q, valid_d;
  logic [itrd_pkg::CharW-1:0]   char_q, char_d;
  logic                         last_q, last_d;
  logic                         bad_q, bad_d;
  logic                         accept;
  logic                         radix_ok;
  logic                         more;
  logic [itrd_pkg::CntW-1:0]    cnt_inc;
  logic                         ram_we;
  logic [itrd_pkg::CharW-1:0]   ram_rdata;
  itrd_pkg::div_req_t           div_req;
  itrd_pkg::div_rsp_t           div_rsp;

  assign accept   = start && !busy;
  assign radix_ok = (radix_q >= itrd_pkg::RadixLowest) && (radix_q <= itrd_pkg::RadixHighest);
  assign cnt_inc  = cnt_q + itrd_pkg::CntW'(1);
  assign more     = (div_rsp.quotient != '0) && (cnt_inc < itrd_pkg::CntW'(itrd_pkg::MaxDigits));
  assign ram_we   = (state_q == StDivide) && div_rsp.done;

  // radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= itrd_pkg::RadixReset;
    end else if (radix_we_i) begin
      radix_q <= radix_wdata_i;
    end
  end

  // sequencer: divide digit by digit, then read the store back in reverse
  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    ptr_d            = ptr_q;
    valid_d          = 1'b0;
    char_d           = char_q;
    last_d           = last_q;
    bad_d            = bad_q;
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quotient;
    div_req.divisor  = radix_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (radix_ok) begin
            div_req.start    = 1'b1;
            div_req.dividend = value_i;
            cnt_d            = '0;
            state_d          = StDivide;
          end else begin
            valid_d = 1'b1;
            char_d  = '0;
            last_d  = 1'b1;
            bad_d   = 1'b1;
          end
        end
      end
      StDivide: begin
        if (div_rsp.done) begin
          cnt_d = cnt_inc;
          if (more) begin
            div_req.start = 1'b1;
          end else begin
            ptr_d   = cnt_q[itrd_pkg::IdxW-1:0];
            state_d = StRead;
          end
        end
      end
      StRead: begin
        state_d = StOut;
      end
      StOut: begin
        valid_d = 1'b1;
        char_d  = ram_rdata;
        last_d  = (ptr_q == '0);
        bad_d   = 1'b0;
        if (ptr_q == '0) begin
          state_d = StIdle;
        end else begin
          ptr_d   = ptr_q - itrd_pkg::IdxW'(1);
          state_d = StRead;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      ptr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    bad_q  <= bad_d;
  end

  // shared divider
  itrd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // digit store, least significant digit at entry 0
  itrd_ram #(
    .Width (itrd_pkg::CharW),
    .Depth (itrd_pkg::MaxDigits)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[itrd_pkg::IdxW-1:0]),
    .wdata_i (itrd_pkg::digit_char(div_rsp.remainder)),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign busy           = (state_q != StIdle);
  assign result_valid_o = valid_q;
  assign character_o    = char_q;
  assign last_o         = last_q;
  assign bad_radix_o    = bad_q;

  // digit count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= itrd_pkg::CntW'(itrd_pkg::MaxDigits))
    else $error("digit count beyond store depth");

  // no result is shown while the divider is still working
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> !result_valid_o)
    else $error("result during division");

  // a bad-radix result is a lone, last, zero character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && bad_radix_o) |-> (last_o && character_o == '0))
    else $error("malformed bad-radix result");

  // a transaction with a bad radix gives its result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !radix_ok) |=> (result_valid_o && bad_radix_o && !busy))
    else $error("bad-radix transaction not answered");

endmodule

// ===== rtl/itrd_ram.sv =====
// generic single-port-write, registered-read ram
module itrd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/itrd_div.sv =====
// restoring divider, one quotient bit per cycle, 32-bit dividend by 6-bit divisor
module itrd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  itrd_pkg::div_req_t req_i,
  output itrd_pkg::div_rsp_t rsp_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [itrd_pkg::BitCntW-1:0]       bit_q, bit_d;
  logic [itrd_pkg::ValueW-1:0]        dvd_q, dvd_d;
  logic [itrd_pkg::RemW-1:0]          rem_q, rem_d;
  logic [itrd_pkg::RadixW-1:0]        dsr_q, dsr_d;
  logic [itrd_pkg::RadixW-1:0]        rem_shift;
  logic                               fits;

  // shift next dividend bit into the partial remainder and trial-subtract
  assign rem_shift = {rem_q, dvd_q[itrd_pkg::ValueW-1]};
  assign fits      = (rem_shift >= dsr_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    bit_d  = bit_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      bit_d  = '1;
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[itrd_pkg::ValueW-2:0], fits};
      rem_d = fits ? itrd_pkg::RemW'(rem_shift - dsr_q) : rem_shift[itrd_pkg::RemW-1:0];
      bit_d = bit_q - itrd_pkg::BitCntW'(1);
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = dvd_q;
  assign rsp_o.remainder = rem_q;

endmodule
